[rtl/c8_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_pkg
// Shared types, command and status codes, sizes and the hex font table of
// the CHIP-8 interpreter core.
// ----------------------------------------------------------------------------
package c8_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int ADDR_W        = $clog2(MEM_BYTES);
  localparam int STACK_DEPTH   = 16;
  localparam int SP_W          = $clog2(STACK_DEPTH + 1);
  localparam int SI_W          = $clog2(STACK_DEPTH);
  localparam int SCREEN_W      = 64;
  localparam int SCREEN_H      = 32;
  localparam int ROW_W         = $clog2(SCREEN_H);
  localparam int FONT_BYTES    = 80;
  localparam logic [ADDR_W-1:0] PROGRAM_START = 12'h200;

  localparam logic [2:0] CMD_MEM_WR = 3'd0;
  localparam logic [2:0] CMD_EXEC   = 3'd1;
  localparam logic [2:0] CMD_KEY    = 3'd2;
  localparam logic [2:0] CMD_TICK   = 3'd3;
  localparam logic [2:0] CMD_ROW_RD = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [ADDR_W-1:0] address;
    logic [7:0]        write_byte;
    logic [3:0]        key_number;
    logic              key_down;
    logic [7:0]        random_byte;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   program_counter;
    logic [1:0]          status;
    logic                screen_changed;
    logic                waiting_key;
    logic                sound_on;
    logic [SCREEN_W-1:0] row_pixels;
  } result_t;

  function automatic logic [7:0] font_byte(input logic [6:0] a);
    logic [7:0] f;
    unique case (a[6:0])
      7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22, 7'd25,
      7'd27, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42, 7'd44, 7'd45,
      7'd47, 7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70, 7'd72, 7'd74, 7'd75,
      7'd77: f = 8'hF0;
      7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46, 7'd51,
      7'd53, 7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68: f = 8'h90;
      7'd5, 7'd7, 7'd8, 7'd37: f = 8'h20;
      7'd6: f = 8'h60;
      7'd9: f = 8'h70;
      7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: f = 8'h10;
      7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76, 7'd78,
      7'd79: f = 8'h80;
      7'd38, 7'd39: f = 8'h40;
      7'd55, 7'd57, 7'd59, 7'd65, 7'd69: f = 8'hE0;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

[rtl/chip8_interpreter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_interpreter_core
// CHIP-8 machine behind a command port, one result transaction per command.
// The in_ channel carries a command: write a memory byte, execute the
// instruction at PC, set a key, tick the timers or read a screen row. The
// out_ channel returns PC, status, screen and key-wait flags, the sound flag
// and the requested row. A command takes one transaction on each channel.
// An instruction runs through fetch, register reads, execute and write-back;
// a clear-screen walks the screen rows, a draw walks its sprite rows and
// Fx55/Fx65 walk the registers, each step being one access to the program,
// screen or register memory. Commands are handled one at a time.
// The result sits in an output register, so the next command is taken while
// the receiver stalls; a second result then waits until the first is taken.
// After reset a pass over every memory address loads the font and clears
// memory, screen and registers; in_ready stays low during that pass.
// ----------------------------------------------------------------------------
module chip8_interpreter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_cmd,
  input  logic [c8_pkg::ADDR_W-1:0]     in_address,
  input  logic [7:0]                    in_write_byte,
  input  logic [3:0]                    in_key_number,
  input  logic                          in_key_down,
  input  logic [7:0]                    in_random_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [c8_pkg::ADDR_W-1:0]     out_program_counter,
  output logic [1:0]                    out_status,
  output logic                          out_screen_changed,
  output logic                          out_waiting_key,
  output logic                          out_sound_on,
  output logic [c8_pkg::SCREEN_W-1:0]   out_row_pixels
);

  c8_pkg::item_t   item;
  c8_pkg::result_t res, res_r;
  logic            seq_idle, res_valid, res_ready, start, out_valid_r;

  assign item.cmd         = in_cmd;
  assign item.address     = in_address;
  assign item.write_byte  = in_write_byte;
  assign item.key_number  = in_key_number;
  assign item.key_down    = in_key_down;
  assign item.random_byte = in_random_byte;

  assign in_ready  = seq_idle;
  assign start     = in_valid && seq_idle;
  assign res_ready = !out_valid_r || out_ready;

  c8_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .item(item), .idle(seq_idle),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_program_counter = res_r.program_counter;
  assign out_status          = res_r.status;
  assign out_screen_changed  = res_r.screen_changed;
  assign out_waiting_key     = res_r.waiting_key;
  assign out_sound_on        = res_r.sound_on;
  assign out_row_pixels      = res_r.row_pixels;

endmodule

[rtl/c8_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_ram
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/c8_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_seq
// Instruction sequencer: owns the program, screen, register and stack
// memories and runs each command as a series of steps that read and write them.
// ----------------------------------------------------------------------------
module c8_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  c8_pkg::item_t     item,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output c8_pkg::result_t   res
);

  localparam int AW   = c8_pkg::ADDR_W;
  localparam int SPW  = c8_pkg::SP_W;
  localparam int SIW  = c8_pkg::SI_W;
  localparam int RW   = c8_pkg::ROW_W;
  localparam int SW   = c8_pkg::SCREEN_W;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_F0    = 5'd2;
  localparam logic [4:0] S_F1    = 5'd3;
  localparam logic [4:0] S_F2    = 5'd4;
  localparam logic [4:0] S_RX    = 5'd5;
  localparam logic [4:0] S_RY    = 5'd6;
  localparam logic [4:0] S_R0    = 5'd7;
  localparam logic [4:0] S_EXEC  = 5'd8;
  localparam logic [4:0] S_RET   = 5'd9;
  localparam logic [4:0] S_CLS   = 5'd10;
  localparam logic [4:0] S_D0    = 5'd11;
  localparam logic [4:0] S_D1    = 5'd12;
  localparam logic [4:0] S_D2    = 5'd13;
  localparam logic [4:0] S_D3    = 5'd14;
  localparam logic [4:0] S_BCD   = 5'd15;
  localparam logic [4:0] S_STRD  = 5'd16;
  localparam logic [4:0] S_STWR  = 5'd17;
  localparam logic [4:0] S_LDRD  = 5'd18;
  localparam logic [4:0] S_LDWR  = 5'd19;
  localparam logic [4:0] S_WF    = 5'd20;
  localparam logic [4:0] S_WX    = 5'd21;
  localparam logic [4:0] S_ROW   = 5'd22;
  localparam logic [4:0] S_DONE  = 5'd23;

  logic [4:0]    state_r, state_nxt;
  logic [AW-1:0] pc_r, pc_nxt;
  logic [15:0]   i_r, i_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [7:0]    dt_r, dt_nxt;
  logic [7:0]    st_r, st_nxt;
  logic [15:0]   keys_r, keys_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   op_r, op_nxt;
  logic [7:0]    hi_r, hi_nxt;
  logic [7:0]    vx_r, vx_nxt;
  logic [7:0]    vy_r, vy_nxt;
  logic [7:0]    rand_r, rand_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          changed_r, changed_nxt;
  logic          waiting_r, waiting_nxt;
  logic [SW-1:0] row_r, row_nxt;
  logic          wf_r, wf_nxt;
  logic          wfv_r, wfv_nxt;
  logic          wx_r, wx_nxt;
  logic [7:0]    wxv_r, wxv_nxt;
  logic          coll_r, coll_nxt;
  logic [14:0]   pbase_r, pbase_nxt;
  logic [7:0]    sprite_r, sprite_nxt;

  logic          m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [7:0]    m_wdata, m_rdata;
  logic          s_we;
  logic [RW-1:0] s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_rdata;
  logic          v_we;
  logic [3:0]    v_waddr, v_raddr;
  logic [7:0]    v_wdata, v_rdata;
  logic          k_we;
  logic [SIW-1:0] k_waddr, k_raddr;
  logic [AW-1:0] k_wdata, k_rdata;

  c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::MEM_BYTES)) u_prog (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );
  c8_ram #(.WIDTH(SW), .DEPTH(c8_pkg::SCREEN_H)) u_screen (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );
  c8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );
  c8_ram #(.WIDTH(AW), .DEPTH(c8_pkg::STACK_DEPTH)) u_stack (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  logic [3:0]    op_x, op_y, op_n;
  logic [7:0]    op_kk;
  logic [AW-1:0] op_nnn, pc_next, pc_skip;
  logic          alu_fl, fl_1e, flag_sel;
  logic [7:0]    vxe, vye;
  logic [8:0]    sum9;
  logic [16:0]   sum17;
  logic [3:0]    hkey;
  logic [7:0]    bcd_h, bcd_r, bcd_t, bcd_o, bcd_d;
  logic [15:0]   bcd_p;
  logic [71:0]   wide;
  logic [SW-1:0] mask_a, mask_b;
  logic          valid_a, valid_b;
  logic [AW-1:0] i_off;
  logic [SPW-1:0] sp_dec;

  assign op_x    = op_r[11:8];
  assign op_y    = op_r[7:4];
  assign op_n    = op_r[3:0];
  assign op_kk   = op_r[7:0];
  assign op_nnn  = op_r[11:0];
  assign pc_next = pc_r + 12'd2;
  assign pc_skip = pc_r + 12'd4;
  assign sum9    = {1'b0, vx_r} + {1'b0, vy_r};
  assign sum17   = {1'b0, i_r} + {9'd0, vx_r};
  assign fl_1e   = sum17 > 17'h00FFF;
  assign i_off   = i_r[AW-1:0] + cnt_r;
  assign sp_dec  = sp_r - SPW'(1);

  always_comb begin
    unique case (op_n)
      4'h4:    alu_fl = sum9[8];
      4'h5:    alu_fl = vx_r >= vy_r;
      4'h6:    alu_fl = vx_r[0];
      4'h7:    alu_fl = vy_r >= vx_r;
      4'hE:    alu_fl = vx_r[7];
      default: alu_fl = 1'b0;
    endcase
    flag_sel = (op_r[15:12] == 4'h8) ? alu_fl : fl_1e;
    vxe = (op_x == 4'hF) ? {7'd0, flag_sel} : vx_r;
    vye = (op_y == 4'hF) ? {7'd0, flag_sel} : vy_r;
  end

  always_comb begin
    hkey = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (keys_r[k]) begin
        hkey = 4'(k);
      end
    end
  end

  always_comb begin
    if (vx_r >= 8'd200) begin
      bcd_h = 8'd2;
      bcd_r = vx_r - 8'd200;
    end else if (vx_r >= 8'd100) begin
      bcd_h = 8'd1;
      bcd_r = vx_r - 8'd100;
    end else begin
      bcd_h = 8'd0;
      bcd_r = vx_r;
    end
    bcd_p = {9'd0, bcd_r[6:0]} * 16'd205;
    bcd_t = {4'd0, bcd_p[14:11]};
    bcd_o = bcd_r - ((bcd_t << 3) + (bcd_t << 1));
    unique case (cnt_r[1:0])
      2'd0:    bcd_d = bcd_h;
      2'd1:    bcd_d = bcd_t;
      default: bcd_d = bcd_o;
    endcase
  end

  assign wide    = {sprite_r, 64'd0} >> pbase_r[5:0];
  assign mask_a  = wide[71:8];
  assign mask_b  = {wide[7:0], 56'd0};
  assign valid_a = pbase_r[14:11] == 4'd0;
  assign valid_b = valid_a && (pbase_r[10:6] != 5'd31);

  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    i_nxt       = i_r;
    sp_nxt      = sp_r;
    dt_nxt      = dt_r;
    st_nxt      = st_r;
    keys_nxt    = keys_r;
    cnt_nxt     = cnt_r;
    op_nxt      = op_r;
    hi_nxt      = hi_r;
    vx_nxt      = vx_r;
    vy_nxt      = vy_r;
    rand_nxt    = rand_r;
    status_nxt  = status_r;
    changed_nxt = changed_r;
    waiting_nxt = waiting_r;
    row_nxt     = row_r;
    wf_nxt      = wf_r;
    wfv_nxt     = wfv_r;
    wx_nxt      = wx_r;
    wxv_nxt     = wxv_r;
    coll_nxt    = coll_r;
    pbase_nxt   = pbase_r;
    sprite_nxt  = sprite_r;
    m_we = 1'b0; m_waddr = cnt_r; m_wdata = 8'd0; m_raddr = pc_r;
    s_we = 1'b0; s_waddr = cnt_r[RW-1:0]; s_wdata = '0; s_raddr = pbase_r[10:6];
    v_we = 1'b0; v_waddr = op_x; v_wdata = wxv_r; v_raddr = op_x;
    k_we = 1'b0; k_waddr = sp_r[SIW-1:0]; k_wdata = pc_r; k_raddr = sp_dec[SIW-1:0];
    res_valid = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_wdata = (cnt_r < AW'(c8_pkg::FONT_BYTES)) ? c8_pkg::font_byte(cnt_r[6:0])
                                                    : 8'd0;
        s_we    = cnt_r < AW'(c8_pkg::SCREEN_H);
        v_we    = cnt_r < AW'(16);
        v_waddr = cnt_r[3:0];
        v_wdata = 8'd0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == AW'(c8_pkg::MEM_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          status_nxt  = c8_pkg::ST_OK;
          changed_nxt = 1'b0;
          waiting_nxt = 1'b0;
          row_nxt     = '0;
          wf_nxt      = 1'b0;
          wx_nxt      = 1'b0;
          rand_nxt    = item.random_byte;
          state_nxt   = S_DONE;
          unique case (item.cmd)
            c8_pkg::CMD_MEM_WR: begin
              m_we    = 1'b1;
              m_waddr = item.address;
              m_wdata = item.write_byte;
            end
            c8_pkg::CMD_EXEC: state_nxt = S_F0;
            c8_pkg::CMD_KEY: keys_nxt[item.key_number] = item.key_down;
            c8_pkg::CMD_TICK: begin
              if (dt_r != 8'd0) dt_nxt = dt_r - 8'd1;
              if (st_r != 8'd0) st_nxt = st_r - 8'd1;
            end
            c8_pkg::CMD_ROW_RD: begin
              s_raddr = item.address[RW-1:0];
              if (item.address < AW'(c8_pkg::SCREEN_H)) state_nxt = S_ROW;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_ROW: begin
        row_nxt   = s_rdata;
        state_nxt = S_DONE;
      end
      S_F0: begin
        m_raddr   = pc_r;
        state_nxt = S_F1;
      end
      S_F1: begin
        hi_nxt    = m_rdata;
        m_raddr   = pc_r + 12'd1;
        state_nxt = S_F2;
      end
      S_F2: begin
        op_nxt    = {hi_r, m_rdata};
        state_nxt = S_RX;
      end
      S_RX: begin
        v_raddr   = op_x;
        state_nxt = S_RY;
      end
      S_RY: begin
        vx_nxt    = v_rdata;
        v_raddr   = op_y;
        state_nxt = S_R0;
      end
      S_R0: begin
        vy_nxt    = v_rdata;
        v_raddr   = 4'd0;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_WX;
        unique case (op_r[15:12])
          4'h0: begin
            if (op_r == 16'h00E0) begin
              cnt_nxt     = '0;
              changed_nxt = 1'b1;
              pc_nxt      = pc_next;
              state_nxt   = S_CLS;
            end else if (op_r == 16'h00EE) begin
              if (sp_r == '0) begin
                status_nxt = c8_pkg::ST_UNDERFLOW;
                state_nxt  = S_DONE;
              end else begin
                sp_nxt    = sp_dec;
                state_nxt = S_RET;
              end
            end else begin
              status_nxt = c8_pkg::ST_UNKNOWN;
              state_nxt  = S_DONE;
            end
          end
          4'h1: pc_nxt = op_nnn;
          4'h2: begin
            if (sp_r >= SPW'(c8_pkg::STACK_DEPTH)) begin
              status_nxt = c8_pkg::ST_OVERFLOW;
            end else begin
              k_we   = 1'b1;
              sp_nxt = sp_r + SPW'(1);
              pc_nxt = op_nnn;
            end
          end
          4'h3: pc_nxt = (vx_r == op_kk) ? pc_skip : pc_next;
          4'h4: pc_nxt = (vx_r != op_kk) ? pc_skip : pc_next;
          4'h5: pc_nxt = (vx_r == vy_r) ? pc_skip : pc_next;
          4'h9: pc_nxt = (vx_r != vy_r) ? pc_skip : pc_next;
          4'h6: begin
            wx_nxt  = 1'b1;
            wxv_nxt = op_kk;
            pc_nxt  = pc_next;
          end
          4'h7: begin
            wx_nxt  = 1'b1;
            wxv_nxt = vx_r + op_kk;
            pc_nxt  = pc_next;
          end
          4'h8: begin
            pc_nxt  = pc_next;
            wx_nxt  = 1'b1;
            wfv_nxt = alu_fl;
            unique case (op_n)
              4'h0: wxv_nxt = vy_r;
              4'h1: wxv_nxt = vx_r | vy_r;
              4'h2: wxv_nxt = vx_r & vy_r;
              4'h3: wxv_nxt = vx_r ^ vy_r;
              4'h4: begin wf_nxt = 1'b1; wxv_nxt = vxe + vye; end
              4'h5: begin wf_nxt = 1'b1; wxv_nxt = vxe - vye; end
              4'h6: begin wf_nxt = 1'b1; wxv_nxt = vxe >> 1; end
              4'h7: begin wf_nxt = 1'b1; wxv_nxt = vye - vxe; end
              4'hE: begin wf_nxt = 1'b1; wxv_nxt = vxe << 1; end
              default: begin
                wx_nxt     = 1'b0;
                pc_nxt     = pc_r;
                status_nxt = c8_pkg::ST_UNKNOWN;
              end
            endcase
          end
          4'hA: begin
            i_nxt  = {4'd0, op_nnn};
            pc_nxt = pc_next;
          end
          4'hB: pc_nxt = op_nnn + {4'd0, v_rdata};
          4'hC: begin
            wx_nxt  = 1'b1;
            wxv_nxt = rand_r & op_kk;
            pc_nxt  = pc_next;
          end
          4'hD: begin
            pbase_nxt   = {7'd0, vx_r} + {1'b0, vy_r, 6'd0};
            cnt_nxt     = '0;
            coll_nxt    = 1'b0;
            changed_nxt = 1'b1;
            pc_nxt      = pc_next;
            state_nxt   = S_D0;
          end
          4'hE: begin
            if (op_kk == 8'h9E) begin
              pc_nxt = keys_r[vx_r[3:0]] ? pc_skip : pc_next;
            end else if (op_kk == 8'hA1) begin
              pc_nxt = keys_r[vx_r[3:0]] ? pc_next : pc_skip;
            end else begin
              status_nxt = c8_pkg::ST_UNKNOWN;
            end
          end
          default: begin
            pc_nxt = pc_next;
            unique case (op_kk)
              8'h07: begin wx_nxt = 1'b1; wxv_nxt = dt_r; end
              8'h0A: begin
                if (keys_r == 16'd0) begin
                  waiting_nxt = 1'b1;
                  pc_nxt      = pc_r;
                end else begin
                  wx_nxt  = 1'b1;
                  wxv_nxt = {4'd0, hkey};
                end
              end
              8'h15: dt_nxt = vx_r;
              8'h18: st_nxt = vx_r;
              8'h1E: begin
                wf_nxt  = 1'b1;
                wfv_nxt = fl_1e;
                i_nxt   = i_r + {8'd0, vxe};
              end
              8'h29: i_nxt = ({8'd0, vx_r} << 2) + {8'd0, vx_r};
              8'h33: begin cnt_nxt = '0; state_nxt = S_BCD; end
              8'h55: begin cnt_nxt = '0; state_nxt = S_STRD; end
              8'h65: begin cnt_nxt = '0; state_nxt = S_LDRD; end
              default: begin
                pc_nxt     = pc_r;
                status_nxt = c8_pkg::ST_UNKNOWN;
              end
            endcase
          end
        endcase
      end
      S_RET: begin
        pc_nxt    = k_rdata + 12'd2;
        state_nxt = S_DONE;
      end
      S_CLS: begin
        s_we    = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[RW-1:0] == RW'(c8_pkg::SCREEN_H - 1)) state_nxt = S_DONE;
      end
      S_D0: begin
        m_raddr = i_off;
        if (cnt_r[3:0] == op_n) begin
          wf_nxt    = 1'b1;
          wfv_nxt   = coll_r;
          state_nxt = S_WF;
        end else begin
          state_nxt = S_D1;
        end
      end
      S_D1: begin
        sprite_nxt = m_rdata;
        s_raddr    = pbase_r[10:6];
        state_nxt  = S_D2;
      end
      S_D2: begin
        s_raddr = pbase_r[10:6] + 5'd1;
        s_waddr = pbase_r[10:6];
        s_wdata = s_rdata ^ mask_a;
        if (valid_a) begin
          s_we     = 1'b1;
          coll_nxt = coll_r | (|(s_rdata & mask_a));
        end
        state_nxt = S_D3;
      end
      S_D3: begin
        s_waddr = pbase_r[10:6] + 5'd1;
        s_wdata = s_rdata ^ mask_b;
        if (valid_b) begin
          s_we     = 1'b1;
          coll_nxt = coll_r | (|(s_rdata & mask_b));
        end
        cnt_nxt   = cnt_r + 1'b1;
        pbase_nxt = pbase_r + 15'd64;
        state_nxt = S_D0;
      end
      S_BCD: begin
        m_we    = 1'b1;
        m_waddr = i_off;
        m_wdata = bcd_d;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[1:0] == 2'd2) state_nxt = S_DONE;
      end
      S_STRD: begin
        v_raddr   = cnt_r[3:0];
        state_nxt = S_STWR;
      end
      S_STWR: begin
        m_we    = 1'b1;
        m_waddr = i_off;
        m_wdata = v_rdata;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[3:0] == op_x) begin
          i_nxt     = i_r + {12'd0, op_x} + 16'd1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_STRD;
        end
      end
      S_LDRD: begin
        m_raddr   = i_off;
        state_nxt = S_LDWR;
      end
      S_LDWR: begin
        v_we    = 1'b1;
        v_waddr = cnt_r[3:0];
        v_wdata = m_rdata;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[3:0] == op_x) begin
          i_nxt     = i_r + {12'd0, op_x} + 16'd1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LDRD;
        end
      end
      S_WF: begin
        v_we      = 1'b1;
        v_waddr   = 4'hF;
        v_wdata   = {7'd0, wfv_r};
        state_nxt = wx_r ? S_WX : S_DONE;
      end
      S_WX: begin
        v_we      = wx_r;
        state_nxt = S_DONE;
        if (wf_r) state_nxt = S_WF;
        if (wf_r) v_we = 1'b0;
        if (wf_r) wf_nxt = 1'b0;
        if (!wf_r) wx_nxt = 1'b0;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle                = state_r == S_IDLE;
  assign res.program_counter = pc_r;
  assign res.status          = status_r;
  assign res.screen_changed  = changed_r;
  assign res.waiting_key     = waiting_r;
  assign res.sound_on        = st_r != 8'd0;
  assign res.row_pixels      = row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      pc_r    <= c8_pkg::PROGRAM_START;
      i_r     <= '0;
      sp_r    <= '0;
      dt_r    <= '0;
      st_r    <= '0;
      keys_r  <= '0;
      wf_r    <= 1'b0;
      wx_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pc_r    <= pc_nxt;
      i_r     <= i_nxt;
      sp_r    <= sp_nxt;
      dt_r    <= dt_nxt;
      st_r    <= st_nxt;
      keys_r  <= keys_nxt;
      wf_r    <= wf_nxt;
      wx_r    <= wx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    hi_r      <= hi_nxt;
    vx_r      <= vx_nxt;
    vy_r      <= vy_nxt;
    rand_r    <= rand_nxt;
    status_r  <= status_nxt;
    changed_r <= changed_nxt;
    waiting_r <= waiting_nxt;
    row_r     <= row_nxt;
    wfv_r     <= wfv_nxt;
    wxv_r     <= wxv_nxt;
    coll_r    <= coll_nxt;
    pbase_r   <= pbase_nxt;
    sprite_r  <= sprite_nxt;
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for chip8_interpreter_core. A directed table walks the
// reset state, field extremes and error codes, then random commands run short
// programs written into memory at PC with random content, plus stack bursts.
// Every result transaction is compared with an in-bench machine model.
// ----------------------------------------------------------------------------
module tb_top;
  import c8_pkg::*;

  localparam logic [3:0] OP_SYS = 4'h0, OP_JP = 4'h1, OP_CALL = 4'h2, OP_SE = 4'h3;
  localparam logic [3:0] OP_SNE = 4'h4, OP_SER = 4'h5, OP_LD = 4'h6, OP_ADD = 4'h7;
  localparam logic [3:0] OP_ALU = 4'h8, OP_SNER = 4'h9, OP_LDI = 4'hA, OP_JPV = 4'hB;
  localparam logic [3:0] OP_RND = 4'hC, OP_DRW = 4'hD, OP_KEY = 4'hE, OP_MISC = 4'hF;
  localparam logic [15:0] OPC_CLS = 16'h00E0, OPC_RET = 16'h00EE;
  localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;
  localparam logic [7:0] KEY_DOWN_SKIP = 8'h9E, KEY_UP_SKIP = 8'hA1;
  localparam logic [7:0] FX_GETDT = 8'h07, FX_WAITK = 8'h0A, FX_SETDT = 8'h15;
  localparam logic [7:0] FX_SETST = 8'h18, FX_ADDI = 8'h1E, FX_FONT = 8'h29;
  localparam logic [7:0] FX_BCD = 8'h33, FX_STORE = 8'h55, FX_LOAD = 8'h65;
  localparam logic [7:0] FX_LIST [9] = '{FX_GETDT, FX_WAITK, FX_SETDT, FX_SETST,
                                         FX_ADDI, FX_FONT, FX_BCD, FX_STORE, FX_LOAD};

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic [2:0] in_cmd = CMD_TICK;
  logic [ADDR_W-1:0] in_address = '0;
  logic [7:0] in_write_byte = '0, in_random_byte = '0;
  logic [3:0] in_key_number = '0;
  logic in_key_down = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic [ADDR_W-1:0] out_program_counter;
  logic [1:0] out_status;
  logic out_screen_changed, out_waiting_key, out_sound_on;
  logic [SCREEN_W-1:0] out_row_pixels;

  chip8_interpreter_core u_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Machine state mirrored by the bench.
  logic [7:0] mach_mem [MEM_BYTES];
  logic [SCREEN_W-1:0] mach_scr [SCREEN_H];
  logic [7:0] mach_v [16];
  logic [11:0] mach_stk [STACK_DEPTH];
  int unsigned mach_sp;
  logic [15:0] mach_i;
  logic [11:0] mach_pc;
  logic [7:0] mach_dt, mach_snd;
  logic [15:0] mach_keys;

  result_t pending_results [$];
  int n_mismatch = 0, n_results = 0, n_items = 0, n_exec = 0, n_draw = 0;
  int n_unknown = 0, n_over = 0, n_under = 0, n_wait = 0;
  bit hold_off_req = 1'b0;

  task automatic machine_reset();
    for (int a = 0; a < MEM_BYTES; a++) mach_mem[a] = (a < FONT_BYTES) ? font_byte(a) : 8'h00;
    foreach (mach_scr[r]) mach_scr[r] = '0;
    foreach (mach_v[r]) mach_v[r] = '0;
    mach_sp = 0;
    mach_i = '0;
    mach_pc = PROGRAM_START;
    mach_dt = '0;
    mach_snd = '0;
    mach_keys = '0;
  endtask

  task automatic run_instruction(input logic [7:0] rnd, output logic [1:0] st,
                                 output logic chg, output logic wait_k);
    logic [15:0] op;
    logic [3:0] x, y, n;
    logic [7:0] kk, xv, yv, bits;
    logic [11:0] nnn, nxt, skp, npc;
    int p;
    op = {mach_mem[mach_pc], mach_mem[12'(mach_pc + 1)]};
    x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0]; nnn = op[11:0];
    nxt = mach_pc + 12'd2; skp = mach_pc + 12'd4; npc = nxt;
    st = ST_OK; chg = 1'b0; wait_k = 1'b0;
    n_exec++;
    case (op[15:12])
      OP_SYS: begin
        if (op == OPC_CLS) begin
          foreach (mach_scr[r]) mach_scr[r] = '0;
          chg = 1'b1;
        end else if (op == OPC_RET) begin
          if (mach_sp == 0) st = ST_UNDERFLOW;
          else begin
            mach_sp--;
            npc = mach_stk[mach_sp] + 12'd2;
          end
        end else st = ST_UNKNOWN;
      end
      OP_JP: npc = nnn;
      OP_CALL: begin
        if (mach_sp >= STACK_DEPTH) st = ST_OVERFLOW;
        else begin
          mach_stk[mach_sp] = mach_pc;
          mach_sp++;
          npc = nnn;
        end
      end
      OP_SE: npc = (mach_v[x] == kk) ? skp : nxt;
      OP_SNE: npc = (mach_v[x] != kk) ? skp : nxt;
      OP_SER: npc = (mach_v[x] == mach_v[y]) ? skp : nxt;
      OP_LD: mach_v[x] = kk;
      OP_ADD: mach_v[x] = mach_v[x] + kk;
      OP_ALU: begin
        case (n)
          ALU_MOV: mach_v[x] = mach_v[y];
          ALU_OR: mach_v[x] = mach_v[x] | mach_v[y];
          ALU_AND: mach_v[x] = mach_v[x] & mach_v[y];
          ALU_XOR: mach_v[x] = mach_v[x] ^ mach_v[y];
          ALU_ADD: begin
            mach_v[15] = ({1'b0, mach_v[x]} + mach_v[y] > 9'd255) ? 8'd1 : 8'd0;
            mach_v[x] = mach_v[x] + mach_v[y];
          end
          ALU_SUB: begin
            mach_v[15] = (mach_v[x] >= mach_v[y]) ? 8'd1 : 8'd0;
            mach_v[x] = mach_v[x] - mach_v[y];
          end
          ALU_SHR: begin
            mach_v[15] = {7'd0, mach_v[x][0]};
            mach_v[x] = mach_v[x] >> 1;
          end
          ALU_SUBN: begin
            mach_v[15] = (mach_v[y] >= mach_v[x]) ? 8'd1 : 8'd0;
            mach_v[x] = mach_v[y] - mach_v[x];
          end
          ALU_SHL: begin
            mach_v[15] = {7'd0, mach_v[x][7]};
            mach_v[x] = mach_v[x] << 1;
          end
          default: st = ST_UNKNOWN;
        endcase
      end
      OP_SNER: npc = (mach_v[x] != mach_v[y]) ? skp : nxt;
      OP_LDI: mach_i = {4'd0, nnn};
      OP_JPV: npc = nnn + {4'd0, mach_v[0]};
      OP_RND: mach_v[x] = rnd & kk;
      OP_DRW: begin
        xv = mach_v[x]; yv = mach_v[y];
        mach_v[15] = 8'd0;
        n_draw++;
        for (int r = 0; r < n; r++) begin
          bits = mach_mem[12'(mach_i + r)];
          for (int c = 0; c < 8; c++) begin
            if (bits[7 - c]) begin
              p = xv + c + (yv + r) * SCREEN_W;
              if (p < SCREEN_W * SCREEN_H) begin
                if (mach_scr[p / SCREEN_W][SCREEN_W - 1 - p % SCREEN_W]) mach_v[15] = 8'd1;
                mach_scr[p / SCREEN_W][SCREEN_W - 1 - p % SCREEN_W] ^= 1'b1;
              end
            end
          end
        end
        chg = 1'b1;
      end
      OP_KEY: begin
        if (kk == KEY_DOWN_SKIP) npc = mach_keys[mach_v[x][3:0]] ? skp : nxt;
        else if (kk == KEY_UP_SKIP) npc = mach_keys[mach_v[x][3:0]] ? nxt : skp;
        else st = ST_UNKNOWN;
      end
      default: begin
        case (kk)
          FX_GETDT: mach_v[x] = mach_dt;
          FX_WAITK: begin
            if (mach_keys == 0) begin
              wait_k = 1'b1;
              npc = mach_pc;
              n_wait++;
            end else
              for (int k = 0; k < 16; k++) if (mach_keys[k]) mach_v[x] = 8'(k);
          end
          FX_SETDT: mach_dt = mach_v[x];
          FX_SETST: mach_snd = mach_v[x];
          FX_ADDI: begin
            mach_v[15] = ({1'b0, mach_i} + mach_v[x] > 17'hFFF) ? 8'd1 : 8'd0;
            mach_i = mach_i + mach_v[x];
          end
          FX_FONT: mach_i = 16'(mach_v[x] * 5);
          FX_BCD: begin
            mach_mem[12'(mach_i)] = mach_v[x] / 100;
            mach_mem[12'(mach_i + 1)] = (mach_v[x] / 10) % 10;
            mach_mem[12'(mach_i + 2)] = mach_v[x] % 10;
          end
          FX_STORE: begin
            for (int k = 0; k <= x; k++) mach_mem[12'(mach_i + k)] = mach_v[k];
            mach_i = mach_i + x + 16'd1;
          end
          FX_LOAD: begin
            for (int k = 0; k <= x; k++) mach_v[k] = mach_mem[12'(mach_i + k)];
            mach_i = mach_i + x + 16'd1;
          end
          default: st = ST_UNKNOWN;
        endcase
      end
    endcase
    if (st == ST_OK) mach_pc = npc;
    if (st == ST_UNKNOWN) n_unknown++;
    if (st == ST_OVERFLOW) n_over++;
    if (st == ST_UNDERFLOW) n_under++;
  endtask

  task automatic machine_step(input item_t it, output result_t res);
    logic [1:0] st;
    logic chg, wk;
    res = '0;
    case (it.cmd)
      CMD_MEM_WR: mach_mem[it.address] = it.write_byte;
      CMD_EXEC: begin
        run_instruction(it.random_byte, st, chg, wk);
        res.status = st;
        res.screen_changed = chg;
        res.waiting_key = wk;
      end
      CMD_KEY: mach_keys[it.key_number] = it.key_down;
      CMD_TICK: begin
        if (mach_dt != 0) mach_dt--;
        if (mach_snd != 0) mach_snd--;
      end
      CMD_ROW_RD: if (it.address < SCREEN_H) res.row_pixels = mach_scr[it.address];
      default: ;
    endcase
    res.program_counter = mach_pc;
    res.sound_on = (mach_snd != 0);
  endtask

  // Directed rows; a typed row carries its own expected PC, status and row.
  typedef struct {
    item_t it;
    bit typed;
    logic [11:0] pc;
    logic [1:0] st;
    logic [63:0] row;
  } drow_t;

  function automatic item_t mk(logic [2:0] c, logic [11:0] a, logic [7:0] b = 8'h00,
                               logic [3:0] k = 4'h0, logic d = 1'b0, logic [7:0] r = 8'h00);
    item_t it;
    it.cmd = c; it.address = a; it.write_byte = b;
    it.key_number = k; it.key_down = d; it.random_byte = r;
    return it;
  endfunction

  drow_t dir_rows [$];

  task automatic add_row(item_t it, bit typed = 0, logic [11:0] pc = 0,
                         logic [1:0] st = ST_OK, logic [63:0] row = 0);
    drow_t d;
    d.it = it; d.typed = typed; d.pc = pc; d.st = st; d.row = row;
    dir_rows.push_back(d);
  endtask

  task automatic send_item(item_t it, bit typed = 0, logic [11:0] pc = 0,
                           logic [1:0] st = ST_OK, logic [63:0] row = 0);
    result_t res;
    in_valid <= 1'b1;
    in_cmd <= it.cmd;
    in_address <= it.address;
    in_write_byte <= it.write_byte;
    in_key_number <= it.key_number;
    in_key_down <= it.key_down;
    in_random_byte <= it.random_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    machine_step(it, res);
    if (typed) begin
      res.program_counter = pc;
      res.status = st;
      res.row_pixels = row;
    end
    pending_results.push_back(res);
    n_items++;
  endtask

  task automatic sender_gap(bit busy);
    int g;
    g = busy ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                  : $urandom_range(0, 3));
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] random_opcode();
    logic [15:0] op;
    op = 16'($urandom);
    case (op[15:12])
      OP_SYS: begin
        case ($urandom_range(0, 3))
          0: op = OPC_CLS;
          1, 2: op = OPC_RET;
          default: ;
        endcase
      end
      OP_DRW: if ($urandom_range(0, 3) != 0) op[3:0] = 4'($urandom_range(0, 5));
      OP_KEY: if ($urandom_range(0, 3) != 0)
        op[7:0] = $urandom_range(0, 1) ? KEY_DOWN_SKIP : KEY_UP_SKIP;
      OP_MISC: if ($urandom_range(0, 4) != 0) op[7:0] = FX_LIST[$urandom_range(0, 8)];
      default: ;
    endcase
    return op;
  endfunction

  task automatic run_opcode(logic [15:0] op, bit busy);
    send_item(mk(CMD_MEM_WR, mach_pc, op[15:8]));
    sender_gap(busy);
    send_item(mk(CMD_MEM_WR, mach_pc + 12'd1, op[7:0]));
    sender_gap(busy);
    send_item(mk(CMD_EXEC, 12'($urandom), 8'($urandom), 4'($urandom), 1'($urandom),
                 8'($urandom)));
    sender_gap(busy);
  endtask

  // Receiver side: random back-pressure with calm stretches and one long hold-off.
  initial begin
    int cnt;
    bit calm;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        cnt = 0;
        while (cnt < 400) begin
          @(posedge clk);
          cnt++;
        end
        hold_off_req = 1'b0;
      end else begin
        if ($urandom_range(0, 199) == 0) calm = ~calm;
        if (calm) out_ready <= 1'b1;
        else if ($urandom_range(0, 99) == 0) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(20, 80)) @(posedge clk);
          out_ready <= 1'b1;
        end else out_ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        e = pending_results.pop_front();
        if (out_program_counter !== e.program_counter || out_status !== e.status ||
            out_screen_changed !== e.screen_changed || out_waiting_key !== e.waiting_key ||
            out_sound_on !== e.sound_on || out_row_pixels !== e.row_pixels) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch %0t: exp pc=%h st=%0d chg=%b wk=%b snd=%b row=%h",
                     $realtime, e.program_counter, e.status, e.screen_changed,
                     e.waiting_key, e.sound_on, e.row_pixels,
                     "\n  got pc=%h st=%0d chg=%b wk=%b snd=%b row=%h",
                     out_program_counter, out_status, out_screen_changed,
                     out_waiting_key, out_sound_on, out_row_pixels);
        end
      end
    end
  end

  initial begin
    int kind;
    machine_reset();
    add_row(mk(CMD_ROW_RD, 12'd0), 1, PROGRAM_START, ST_OK, 64'd0);
    add_row(mk(CMD_ROW_RD, 12'd31), 1, PROGRAM_START, ST_OK, 64'd0);
    add_row(mk(CMD_ROW_RD, 12'hFFF), 1, PROGRAM_START, ST_OK, 64'd0);
    add_row(mk(3'd5, 12'hFFF, 8'hFF, 4'hF, 1'b1, 8'hFF), 1, PROGRAM_START, ST_OK, 64'd0);
    add_row(mk(3'd7, 12'h000), 1, PROGRAM_START, ST_OK, 64'd0);
    add_row(mk(CMD_EXEC, 12'h000), 1, PROGRAM_START, ST_UNKNOWN, 64'd0);
    add_row(mk(CMD_MEM_WR, 12'h201, OPC_RET[7:0]));
    add_row(mk(CMD_EXEC, 12'h000), 1, PROGRAM_START, ST_UNDERFLOW, 64'd0);
    add_row(mk(CMD_MEM_WR, 12'hFFF, 8'hFF));
    add_row(mk(CMD_MEM_WR, 12'h201, OPC_CLS[7:0]));
    add_row(mk(CMD_EXEC, 12'h000));
    add_row(mk(CMD_MEM_WR, 12'h202, {OP_MISC, 4'h3}));
    add_row(mk(CMD_MEM_WR, 12'h203, FX_WAITK));
    add_row(mk(CMD_EXEC, 12'h000));
    add_row(mk(CMD_KEY, 12'h000, 8'h00, 4'hF, 1'b1));
    add_row(mk(CMD_EXEC, 12'h000));
    add_row(mk(CMD_MEM_WR, 12'h204, {OP_RND, 4'h0}));
    add_row(mk(CMD_MEM_WR, 12'h205, 8'hFF));
    add_row(mk(CMD_EXEC, 12'h000, 8'h00, 4'h0, 1'b0, 8'hFF));
    add_row(mk(CMD_MEM_WR, 12'h206, {OP_DRW, 4'h0}));
    add_row(mk(CMD_MEM_WR, 12'h207, 8'h3F));
    add_row(mk(CMD_EXEC, 12'h000));
    add_row(mk(CMD_ROW_RD, 12'd0));
    add_row(mk(CMD_KEY, 12'h000, 8'h00, 4'hF, 1'b0));
    add_row(mk(CMD_TICK, 12'h000));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].pc, dir_rows[i].st,
                dir_rows[i].row);
      sender_gap(0);
    end

    while (n_items < 675) begin
      if (n_items > 300 && n_items < 310) begin
        hold_off_req = 1'b1;
        for (int k = 0; k < 8; k++) run_opcode(random_opcode(), 1);
      end else if (n_items > 150 && n_items < 160) begin
        for (int k = 0; k <= STACK_DEPTH; k++)
          run_opcode({OP_CALL, 12'($urandom)}, 0);
        for (int k = 0; k <= STACK_DEPTH + 1; k++) run_opcode(OPC_RET, 0);
      end else begin
        kind = $urandom_range(0, 9);
        if (kind < 6) run_opcode(random_opcode(), 0);
        else begin
          case ($urandom_range(0, 4))
            0: send_item(mk(CMD_MEM_WR, 12'($urandom), 8'($urandom)));
            1: send_item(mk(CMD_KEY, 12'($urandom), 8'($urandom), 4'($urandom),
                            1'($urandom)));
            2: send_item(mk(CMD_TICK, 12'($urandom)));
            3: send_item(mk(CMD_ROW_RD, $urandom_range(0, 9) ? 12'($urandom_range(0, 31))
                                                             : 12'($urandom)));
            default: send_item(mk(3'($urandom_range(5, 7)), 12'($urandom), 8'($urandom),
                                  4'($urandom), 1'($urandom), 8'($urandom)));
          endcase
          sender_gap(0);
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Ran %0d commands (%0d instructions, %0d draws) and checked %0d results.",
             n_items, n_exec, n_draw, n_results);
    $display("Unknown opcodes %0d, stack overflows %0d, underflows %0d, key waits %0d.",
             n_unknown, n_over, n_under, n_wait);
    if (n_mismatch == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
